>>> hw/rtl/heron_square_root_assert.svh
// assertion macros for the square root block
`ifndef HERON_SQUARE_ROOT_ASSERT_SVH
`define HERON_SQUARE_ROOT_ASSERT_SVH

// implication checked every clock outside reset
`define HSR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("heron_square_root: check failed");

// next-cycle implication outside reset
`define HSR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("heron_square_root: check failed");

`endif

>>> hw/rtl/hsr_pkg.sv
// ----------------------------------------------------------------------------
// hsr_pkg
// types and constants shared by the square root controller and datapath
// ----------------------------------------------------------------------------
package hsr_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned XW          = 32;
  localparam int unsigned IterW       = 6;
  localparam int unsigned PassW       = 7;

  localparam logic [IterW-1:0] MaxIterRst = 6'd20;
  localparam logic [XW-1:0]    TolRst     = 32'd4295;

  // configuration register indexes
  localparam logic [0:0] RegMaxIter = 1'b0;
  localparam logic [0:0] RegTol     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_CHECK,
    ST_DONE
  } hsr_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture radicand, set first estimate
    logic div_start;  // begin a quotient
    logic div_step;   // one quotient bit
    logic mul;        // register tolerance*x and new estimate
    logic commit;     // estimate <= new estimate, count a pass
  } hsr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;   // last quotient bit this cycle
    logic zero;       // new estimate is zero
    logic going;      // change above tolerance
  } hsr_sts_t;

endpackage

>>> hw/rtl/hsr_ctrl.sv
// ----------------------------------------------------------------------------
// hsr_ctrl
// sequencer for the heron passes
// ----------------------------------------------------------------------------
module hsr_ctrl
  import hsr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [IterW-1:0] max_iter_i,
  input  logic [PassW-1:0] passes_i,
  input  hsr_sts_t         sts_i,
  output hsr_cmd_t         cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  hsr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    done_o  = 1'b0;
    busy_o  = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.commit = 1'b1;
        // passes_i still counts passes before this one
        if (sts_i.zero || !sts_i.going || (passes_i == {1'b0, max_iter_i})) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/hsr_dp.sv
// ----------------------------------------------------------------------------
// hsr_dp
// estimate, radix-2 restoring divider, change test
// ----------------------------------------------------------------------------
module hsr_dp
  import hsr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hsr_cmd_t         cmd_i,
  input  logic [XW-1:0]    radicand_i,
  input  logic [XW-1:0]    tol_i,
  output hsr_sts_t         sts_o,
  output logic [XW-1:0]    root_o,
  output logic [PassW-1:0] passes_o
);

  localparam int unsigned NW   = XW + FRAC_BITS;   // dividend width
  localparam int unsigned CntW = $clog2(NW);

  logic [XW-1:0]    x_q, est_q, nxt_q;
  logic [NW-1:0]    num_q, quo_q;
  logic [XW:0]      rem_q;
  logic [CntW-1:0]  cnt_q;
  logic [63:0]      prod_q, dsh_q;
  logic [PassW-1:0] pass_q;

  logic [XW+1:0]    trial;
  logic [XW:0]      rem_sh;
  logic [NW:0]      sum;
  logic [XW-1:0]    nxt_c, diff_c;
  logic [NW-1:0]    quo_n;

  assign rem_sh = {rem_q[XW-1:0], num_q[NW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b0, est_q};
  assign quo_n  = {quo_q[NW-2:0], ~trial[XW+1]};

  // new estimate from final quotient, saturated
  assign sum    = ({{(NW-XW+1){1'b0}}, est_q} + {1'b0, quo_q}) >> 1;
  assign nxt_c  = (|sum[NW:XW]) ? '1 : sum[XW-1:0];
  assign diff_c = (nxt_c >= est_q) ? nxt_c - est_q : est_q - nxt_c;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= radicand_i;
      est_q <= XW'(({1'b0, radicand_i} + (XW+1)'(1 << FRAC_BITS)) >> 1);
    end else if (cmd_i.commit) begin
      est_q <= nxt_q;
    end
    if (cmd_i.load || cmd_i.div_start) begin
      num_q <= NW'(cmd_i.load ? radicand_i : x_q) << FRAC_BITS;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= num_q << 1;
      rem_q <= trial[XW+1] ? rem_sh : trial[XW:0];
      quo_q <= quo_n;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.mul) begin
      nxt_q  <= nxt_c;
      prod_q <= 64'(tol_i) * 64'(x_q);
      dsh_q  <= {diff_c, 32'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= '0;
    end else if (cmd_i.load) begin
      pass_q <= '0;
    end else if (cmd_i.commit) begin
      pass_q <= pass_q + 1'b1;
    end
  end

  assign sts_o.div_last = (cnt_q == CntW'(NW - 1));
  assign sts_o.zero     = (nxt_q == '0);
  assign sts_o.going    = (dsh_q > prod_q);
  assign root_o         = nxt_q;
  assign passes_o       = pass_q;

endmodule

>>> hw/rtl/heron_square_root.sv
// ----------------------------------------------------------------------------
// heron_square_root
// Q16.16 square root by heron iteration with a bit-serial divider
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// request   in         start, busy         radicand_i
// result    out        done_o strobe       root_o, passes_o
// config    in         cfg_valid_i/ready_o cfg_index_i, cfg_data_i
//
// each pass runs a 32+FRAC_BITS bit quotient through the divider, then the
// multiply and check states; every pass of an item uses the shared divider
// busy is high from accept through the done_o strobe cycle
// reset clears control state and loads the register defaults
// the receiver cannot stall; results appear for one cycle
// ----------------------------------------------------------------------------
module heron_square_root
  import hsr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [XW-1:0]    radicand_i,
  output logic             done_o,
  output logic [XW-1:0]    root_o,
  output logic [PassW-1:0] passes_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [0:0]       cfg_index_i,
  input  logic [XW-1:0]    cfg_data_i
);

  logic [IterW-1:0] max_iter_q;
  logic [XW-1:0]    tol_q;
  hsr_cmd_t         cmd;
  hsr_sts_t         sts;
  logic [PassW-1:0] pass_cnt;

  // config writes always taken; the user writes only while idle, not enforced
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MaxIterRst;
      tol_q      <= TolRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegMaxIter: max_iter_q <= cfg_data_i[IterW-1:0];
        RegTol:     tol_q      <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  hsr_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i    (start),
    .max_iter_i (max_iter_q),
    .passes_i   (pass_cnt),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy),
    .done_o     (done_o)
  );

  hsr_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .radicand_i,
    .tol_i      (tol_q),
    .sts_o      (sts),
    .root_o,
    .passes_o   (pass_cnt)
  );

  assign passes_o = pass_cnt;

endmodule

>>> hw/rtl/hsr_checker.sv
// ----------------------------------------------------------------------------
// hsr_checker
// port-level checks for the square root block
// ----------------------------------------------------------------------------
`include "heron_square_root_assert.svh"

module hsr_checker
  import hsr_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic [PassW-1:0] passes_o
);

  `HSR_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `HSR_ASSERT_IMP(a_done_busy, done_o, busy)
  `HSR_ASSERT_NXT(a_done_idle, done_o, !busy)
  `HSR_ASSERT_IMP(a_done_pass, done_o, passes_o != '0)

endmodule

bind heron_square_root hsr_checker u_hsr_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .passes_o
);

>>> test/tb_heron_square_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heron_square_root
// drives radicands through the heron square root block, predicts each root
// and pass count from the current register settings, and checks every result
// ----------------------------------------------------------------------------
module tb_heron_square_root;
  import hsr_pkg::*;

  localparam int unsigned Frac = FracBitsDef;
  // 64 passes plus slack, times the sender gap, several times over
  localparam int unsigned WatchLimit = 40000;

  typedef struct packed {
    logic [XW-1:0]    root;
    logic [PassW-1:0] passes;
  } sqrt_res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [XW-1:0]    radicand_i = '0;
  logic             done_o;
  logic [XW-1:0]    root_o;
  logic [PassW-1:0] passes_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [0:0]       cfg_index_i = RegMaxIter;
  logic [XW-1:0]    cfg_data_i = '0;

  // predictor copy of the registers
  logic [IterW-1:0] iter_limit = MaxIterRst;
  logic [XW-1:0]    tol_thresh = TolRst;

  sqrt_res_t   expected_roots[$];
  int unsigned mismatches = 0;
  int unsigned roots_seen = 0;
  int unsigned requests_sent = 0;
  int unsigned idle_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  heron_square_root dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .radicand_i (radicand_i),
    .done_o     (done_o),
    .root_o     (root_o),
    .passes_o   (passes_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // heron iteration at the block's widths
  function automatic sqrt_res_t heron_root(logic [XW-1:0] x);
    logic [XW-1:0]    est;
    logic [63:0]      quot;
    logic [63:0]      sum;
    logic [XW-1:0]    nxt;
    logic [63:0]      delta;
    logic             going;
    int unsigned      k;
    sqrt_res_t        res;
    est   = XW'((64'(x) + (64'd1 << Frac)) >> 1);
    going = 1'b1;
    k     = 0;
    res.root = est;
    while (k <= iter_limit && going) begin
      quot = (64'(x) << Frac) / 64'(est);
      sum  = (64'(est) + quot) >> 1;
      nxt  = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[XW-1:0];
      delta = (nxt >= est) ? 64'(nxt - est) : 64'(est - nxt);
      k++;
      res.root = nxt;
      if (nxt == '0) break;
      going = (delta << 32) > 64'(tol_thresh) * 64'(x);
      est = nxt;
    end
    res.passes = PassW'(k);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [XW-1:0] got, logic [XW-1:0] want);
    $display("mismatch %0s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // result checker: done_o is a one-cycle strobe, sampled at the edge
  always @(posedge clk_i) begin
    sqrt_res_t want;
    if (rst_ni && done_o) begin
      roots_seen++;
      if (expected_roots.size() == 0) begin
        report_mismatch("unexpected root", root_o, '0);
      end else begin
        want = expected_roots.pop_front();
        if (root_o !== want.root) report_mismatch("root", root_o, want.root);
        if (passes_o !== want.passes) report_mismatch("passes", XW'(passes_o), XW'(want.passes));
      end
    end
  end

  // watchdog on cycles with no accepted request, result or write
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("timeout: no progress for %0d cycles", idle_cycles);
        $display("tb_heron_square_root failed");
        $finish;
      end
    end
  end

  // start stays high after an accept; busy keeps it from being taken again
  task automatic send_radicand(logic [XW-1:0] x, bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    radicand_i <= x;
    do @(posedge clk_i); while (busy);
    expected_roots.push_back(heron_root(x));
    requests_sent++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk_i);
    // done_o is the last busy cycle, leave a margin before touching registers
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [XW-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegMaxIter) iter_limit = value[IterW-1:0];
    else tol_thresh = value;
  endtask

  // extremes of the radicand, zero and saturation cases at reset settings
  task automatic test_directed;
    logic [XW-1:0] edge_vals[$];
    edge_vals = '{32'd0, 32'd1, 32'd2, 32'h0001_0000, 32'h0004_0000, 32'hFFFF_FFFF,
                  32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF,
                  32'h5555_5555, 32'hAAAA_AAAA};
    foreach (edge_vals[i]) send_radicand(edge_vals[i], 1'b0);
  endtask

  // register extremes: single pass, longest run, no tolerance, huge tolerance
  task automatic test_register_extremes;
    write_reg(RegMaxIter, '0);
    send_radicand(32'h0009_0000, 1'b0);
    send_radicand(32'hFFFF_FFFF, 1'b0);
    write_reg(RegMaxIter, 32'd63);
    write_reg(RegTol, '0);
    send_radicand(32'd0, 1'b0);
    send_radicand(32'h0002_0000, 1'b0);
    send_radicand(32'hFFFF_FFFF, 1'b0);
    write_reg(RegTol, 32'hFFFF_FFFF);
    send_radicand(32'h0010_0000, 1'b0);
    send_radicand(32'd3, 1'b0);
  endtask

  // random radicands over several register settings, mixed gap and back-to-back
  task automatic test_random;
    logic [XW-1:0] x;
    for (int phase = 0; phase < 7; phase++) begin
      write_reg(RegMaxIter, (phase == 0) ? 32'd20 : $urandom_range(0, 63));
      write_reg(RegTol, (phase == 0) ? 32'd4295 : $urandom() >> $urandom_range(0, 31));
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(0, 3))
          0: x = $urandom();
          1: x = $urandom() >> $urandom_range(0, 31);
          2: x = $urandom_range(0, 16);
          default: x = 32'hFFFF_FFFF - $urandom_range(0, 255);
        endcase
        send_radicand(x, phase % 3 != 2);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_random();
    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d radicands and %0d roots over several register settings",
             requests_sent, roots_seen);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("tb_heron_square_root passed");
    end else begin
      $display("tb_heron_square_root failed");
    end
    $finish;
  end

endmodule
